[rtl/dfa_pkg.sv]
// ----------------------------------------------------------------------------
// dfa_pkg - shared types and constants of the double-ended frame allocator
// Field widths, default region geometry, operation codes and the item
// layouts of the request and response channels.
// ----------------------------------------------------------------------------
package dfa_pkg;

  // Field widths of the channel items
  localparam int unsigned OffsetW = 21;
  localparam int unsigned SizeW   = 21;
  localparam int unsigned AlignW  = 13;

  // Default region geometry
  localparam longint unsigned RegionBytesDef = 64'd1048576;
  localparam int unsigned     PageBytesDef   = 4096;

  // Request operation codes
  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_SWAP  = 1'b1
  } dfa_op_e;

  // Request item
  typedef struct packed {
    dfa_op_e             operation;
    logic [SizeW-1:0]    request_bytes;
    logic [AlignW-1:0]   align_bytes;
  } dfa_req_t;

  // Response item
  typedef struct packed {
    logic [OffsetW-1:0]  block_offset;
    logic                overflow;
    logic                commit_valid;
    logic [OffsetW-1:0]  commit_offset;
    logic [OffsetW-1:0]  commit_length;
  } dfa_rsp_t;

endpackage

[rtl/dfa_req_if.sv]
// ----------------------------------------------------------------------------
// dfa_req_if - request channel of the frame allocator
// Valid/ready handshake carrying one allocate or swap request item.
// ----------------------------------------------------------------------------
interface dfa_req_if;
  logic              valid;
  logic              ready;
  dfa_pkg::dfa_req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/dfa_rsp_if.sv]
// ----------------------------------------------------------------------------
// dfa_rsp_if - response channel of the frame allocator
// Valid/ready handshake carrying one grant/commit result item.
// ----------------------------------------------------------------------------
interface dfa_rsp_if;
  logic              valid;
  logic              ready;
  dfa_pkg::dfa_rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/dfa_core.sv]
// ----------------------------------------------------------------------------
// dfa_core - allocator state and single-pass request datapath
// Holds both region ends and both commit edges. Computes the result of the
// registered request combinationally and updates the state when it fires.
// ----------------------------------------------------------------------------
module dfa_core #(
  parameter longint unsigned REGION_BYTES = dfa_pkg::RegionBytesDef,
  parameter int unsigned     PAGE_BYTES   = dfa_pkg::PageBytesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dfa_pkg::dfa_req_t req_i,
  input  logic              fire_i,
  output dfa_pkg::dfa_rsp_t rsp_o
);
  import dfa_pkg::*;

  // State width holds 0..REGION_BYTES; datapath width has headroom for sums
  localparam int unsigned AW = $clog2(REGION_BYTES + 1);
  localparam int unsigned SW = ((AW > OffsetW) ? AW : OffsetW) + 2;
  localparam logic [AW-1:0] RegionA  = AW'(REGION_BYTES);
  localparam logic [SW-1:0] PageMask = SW'(PAGE_BYTES - 1);

  logic [AW-1:0] low_top_q, low_top_d;
  logic [AW-1:0] high_bottom_q, high_bottom_d;
  logic [AW-1:0] low_edge_q, low_edge_d;
  logic [AW-1:0] high_edge_q, high_edge_d;
  logic          all_committed_q, all_committed_d;
  logic          grow_low_q, grow_low_d;

  // Widened operands
  logic [SW-1:0]     lt_w, hb_w, le_w, he_w, size_w, amask;
  logic [AlignW-1:0] align_eff;
  logic [SW-1:0]     ptr, top, low_end, nb, start;

  assign lt_w      = SW'(low_top_q);
  assign hb_w      = SW'(high_bottom_q);
  assign le_w      = SW'(low_edge_q);
  assign he_w      = SW'(high_edge_q);
  assign size_w    = SW'(req_i.request_bytes);
  assign align_eff = (req_i.align_bytes == '0) ? AlignW'(1) : req_i.align_bytes;
  assign amask     = SW'(align_eff - AlignW'(1));

  // Low end: align up, bump by size, round commit end to page
  assign ptr     = (lt_w + amask) & ~amask;
  assign top     = ptr + size_w;
  assign low_end = (top + PageMask) & ~PageMask;

  // High end: move down by size, align down, round commit start to page
  assign nb    = (hb_w - size_w) & ~amask;
  assign start = nb & ~PageMask;

  // Result and next state
  always_comb begin
    low_top_d       = low_top_q;
    high_bottom_d   = high_bottom_q;
    low_edge_d      = low_edge_q;
    high_edge_d     = high_edge_q;
    all_committed_d = all_committed_q;
    grow_low_d      = grow_low_q;
    rsp_o           = '0;

    if (req_i.operation == OP_SWAP) begin
      if (grow_low_q) begin
        high_bottom_d = RegionA;
        grow_low_d    = 1'b0;
      end else begin
        low_top_d  = '0;
        grow_low_d = 1'b1;
      end
    end else if (grow_low_q) begin
      if (top > hb_w) begin
        rsp_o.overflow = 1'b1;
      end else begin
        rsp_o.block_offset = OffsetW'(ptr);
        low_top_d          = AW'(top);
        if (!all_committed_q && (top > le_w)) begin
          rsp_o.commit_valid  = 1'b1;
          rsp_o.commit_offset = OffsetW'(le_w);
          if (low_end > he_w) begin
            rsp_o.commit_length = OffsetW'(he_w - le_w);
            low_edge_d          = RegionA;
            high_edge_d         = '0;
            all_committed_d     = 1'b1;
          end else begin
            rsp_o.commit_length = OffsetW'(low_end - le_w);
            low_edge_d          = AW'(low_end);
          end
        end
      end
    end else begin
      if ((size_w > hb_w) || (nb < lt_w)) begin
        rsp_o.overflow = 1'b1;
      end else begin
        rsp_o.block_offset = OffsetW'(nb);
        high_bottom_d      = AW'(nb);
        if (!all_committed_q && (nb < he_w)) begin
          rsp_o.commit_valid = 1'b1;
          if (start < le_w) begin
            rsp_o.commit_offset = OffsetW'(le_w);
            rsp_o.commit_length = OffsetW'(he_w - le_w);
            low_edge_d          = RegionA;
            high_edge_d         = '0;
            all_committed_d     = 1'b1;
          end else begin
            rsp_o.commit_offset = OffsetW'(start);
            rsp_o.commit_length = OffsetW'(he_w - start);
            high_edge_d         = AW'(start);
          end
        end
      end
    end
  end

  // State registers, updated once per processed request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_top_q       <= '0;
      high_bottom_q   <= RegionA;
      low_edge_q      <= '0;
      high_edge_q     <= RegionA;
      all_committed_q <= 1'b0;
      grow_low_q      <= 1'b1;
    end else if (fire_i) begin
      low_top_q       <= low_top_d;
      high_bottom_q   <= high_bottom_d;
      low_edge_q      <= low_edge_d;
      high_edge_q     <= high_edge_d;
      all_committed_q <= all_committed_d;
      grow_low_q      <= grow_low_d;
    end
  end

endmodule

[rtl/double_ended_frame_allocator.sv]
// ----------------------------------------------------------------------------
// double_ended_frame_allocator - frame allocator growing from both ends
// Usage:
//   req_i carries one item per handshake: an allocate (size, alignment) or a
//   swap of the growth direction. rsp_o returns exactly one item for each
//   request: the granted offset, an overflow flag, and the page range that
//   must newly be committed (all zero for a swap or a refused request).
//   A request accepted on req_i waits in the input register, then the
//   single-pass datapath writes the result register while it updates the
//   allocator state.
//   Throughput is one item per cycle while rsp_o does not stall; the state
//   feedback through the align/add/compare datapath is combinational.
//   When rsp_o stalls, the result register and the input register both hold;
//   up to two items are in flight and req_i.ready drops only once both are
//   occupied and the result is not being taken.
//   Reset (rst_ni low, asynchronous) empties the pipeline, puts the low end
//   and the low commit edge at 0, the high end and the high commit edge at
//   REGION_BYTES, and selects growth from the low end.
// ----------------------------------------------------------------------------
module double_ended_frame_allocator #(
  parameter longint unsigned REGION_BYTES = dfa_pkg::RegionBytesDef,
  parameter int unsigned     PAGE_BYTES   = dfa_pkg::PageBytesDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  dfa_req_if.sink   req_i,
  dfa_rsp_if.source rsp_o
);
  import dfa_pkg::*;

  logic     s1_valid_q;
  dfa_req_t s1_req_q;
  logic     rsp_valid_q;
  dfa_rsp_t rsp_data_q;
  dfa_rsp_t core_rsp;
  logic     s1_adv;
  logic     req_fire;

  // Handshake control
  assign s1_adv      = s1_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || s1_adv;
  assign req_fire    = req_i.valid && req_i.ready;

  // Input register valid and result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (req_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      s1_req_q <= req_i.data;
    end
    if (s1_adv) begin
      rsp_data_q <= core_rsp;
    end
  end

  // Allocator state and datapath
  dfa_core #(
    .REGION_BYTES (REGION_BYTES),
    .PAGE_BYTES   (PAGE_BYTES)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (s1_req_q),
    .fire_i (s1_adv),
    .rsp_o  (core_rsp)
  );

  assign rsp_o.valid = rsp_valid_q;
  assign rsp_o.data  = rsp_data_q;

  // An item taken into an empty pipeline passes the input register, then shows up as a result
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_fire && !s1_valid_q && !rsp_valid_q) |=> (s1_valid_q ##1 rsp_valid_q))
    else $error("request did not reach the result register in two cycles");

  // A held request is never dropped while the result side stalls
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_req_q)))
    else $error("stalled request lost from the input register");

  // A refused request grants nothing and commits nothing
  a_ovf_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && core_rsp.overflow) |->
      (!core_rsp.commit_valid && (core_rsp.block_offset == '0)))
    else $error("overflow result carries a grant or a commit");

endmodule
